### rtl/core/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define ASSERT_CLKD(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/core/sthc_pkg.sv
`timescale 1ns / 1ps

package sthc_pkg;

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 56;

  localparam logic [CfgIdxW-1:0] RegTempCoef1 = 8'd0;
  localparam logic [CfgIdxW-1:0] RegTempCoef2 = 8'd1;
  localparam logic [CfgIdxW-1:0] RegTempCoef3 = 8'd2;
  localparam logic [CfgIdxW-1:0] RegHumCoef1  = 8'd3;
  localparam logic [CfgIdxW-1:0] RegHumCoef2  = 8'd4;
  localparam logic [CfgIdxW-1:0] RegHumCoef3  = 8'd5;
  localparam logic [CfgIdxW-1:0] RegHumCoef45 = 8'd6;
  localparam logic [CfgIdxW-1:0] RegHumCoef6  = 8'd7;

  localparam logic CmdTemp = 1'b0;
  localparam logic CmdHum  = 1'b1;

  localparam logic [31:0] HumOffsetT  = 32'd76800;
  localparam logic [31:0] HumRoundA   = 32'd16384;
  localparam logic [31:0] HumBiasB    = 32'd32768;
  localparam logic [31:0] HumBiasC    = 32'd2097152;
  localparam logic [31:0] HumRoundD   = 32'd8192;
  localparam logic [31:0] HumClampMax = 32'd419430400;
  localparam logic [31:0] TempRound   = 32'd128;
  localparam logic [31:0] TempScale   = 32'd5;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_T_MUL1, ST_T_POST1, ST_T_MUL2, ST_T_POST2,
    ST_T_MUL3, ST_T_POST3, ST_T_MUL4, ST_T_POST4,
    ST_H_MUL1, ST_H_POST1, ST_H_MUL2, ST_H_POST2,
    ST_H_MUL3, ST_H_POST3, ST_H_MUL4, ST_H_POST4,
    ST_H_MUL5, ST_H_POST5, ST_H_MUL6, ST_H_POST6,
    ST_H_MUL7, ST_H_POST7, ST_H_MUL8, ST_H_POST8,
    ST_DONE
  } sthc_state_e;

endpackage

### rtl/core/sensor_temp_humidity_compensation_unit.sv
`timescale 1ns / 1ps

// Temperature / humidity compensation for raw sensor ADC readings.
// Input stream: one request per sample; tuser[0] is the command (0 temperature,
// 1 humidity), tdata[19:0] the raw reading (humidity uses bits 15:0).
// Output stream: one result per request; tdata[31:0] temperature in 0.01 C
// (zero for humidity), tdata[48:32] humidity times 1024 (zero for temperature).
// Config channel: cfg_index_i selects a coefficient register 0..7, cfg_data_i
// holds its value; writes are always taken, unknown indexes are dropped.
// All products go through one shared 32x32 multiplier with a registered
// product; each multiply has a MUL state and a POST state under a small sequencer.
// Temperature uses 4 products, humidity 8; the sequencer steps through their MUL and
// POST states, then DONE loads the output register. The input is not ready while a
// request is in progress, so a new request is taken only once the last one is done.
// A temperature request updates the stored fine temperature used by humidity.
// If the receiver stalls, the finished result waits in the output register and
// the next request is accepted; a second result then waits until the first
// one is taken.
// Reset clears coefficients, fine temperature and the output valid.
module sensor_temp_humidity_compensation_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [sthc_pkg::InDataW-1:0]       s_axis_tdata,  // raw_sample, zero pad
  input  logic                               s_axis_tuser,  // command
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [sthc_pkg::OutDataW-1:0]      m_axis_tdata,  // temperature_centi, humidity_q10, zero pad
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [sthc_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [sthc_pkg::CfgDataW-1:0]      cfg_data_i
);

  sthc_pkg::sthc_state_e state_q, state_d;

  logic [15:0] tc1_q, tc2_q, tc3_q, hc2_q;
  logic [7:0]  hc1_q, hc3_q, hc6_q;
  logic [23:0] hc45_q;
  logic [31:0] fine_q, fine_d;
  logic        cmd_q;
  logic [19:0] adc_q;
  logic [31:0] prod_q, prod_d;
  logic [31:0] pa_q, pa_d, wa_q, wa_d, wb_q, wb_d, r_q, r_d;
  logic        out_valid_q;
  logic [sthc_pkg::OutDataW-1:0] out_data_q;

  logic [31:0] mul_a, mul_b;
  logic [31:0] t1, t2, t3, h1, h2, h3, h5, h6, x, diff, sat, tmp;
  logic [11:0] h4;
  logic        in_acc, out_load;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == sthc_pkg::ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == sthc_pkg::ST_DONE) && (!out_valid_q || m_axis_tready);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign t1 = {16'b0, tc1_q};
  assign t2 = {{16{tc2_q[15]}}, tc2_q};
  assign t3 = {{16{tc3_q[15]}}, tc3_q};
  assign h1 = {24'b0, hc1_q};
  assign h2 = {{16{hc2_q[15]}}, hc2_q};
  assign h3 = {24'b0, hc3_q};
  assign h4 = hc45_q[11:0];
  assign h5 = {{20{hc45_q[23]}}, hc45_q[23:12]};
  assign h6 = {{24{hc6_q[7]}}, hc6_q};
  assign x  = fine_q - sthc_pkg::HumOffsetT;

  // shared multiplier, low 32 bits wrap
  assign prod_d = mul_a * mul_b;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sthc_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = (s_axis_tuser == sthc_pkg::CmdHum) ? sthc_pkg::ST_H_MUL1
                                                       : sthc_pkg::ST_T_MUL1;
        end
      end
      sthc_pkg::ST_T_POST4, sthc_pkg::ST_H_POST8: state_d = sthc_pkg::ST_DONE;
      sthc_pkg::ST_DONE: begin
        if (!out_valid_q || m_axis_tready) state_d = sthc_pkg::ST_IDLE;
      end
      default: state_d = sthc_pkg::sthc_state_e'(state_q + 5'd1);
    endcase
  end

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    pa_d   = pa_q;
    wa_d   = wa_q;
    wb_d   = wb_q;
    r_d    = r_q;
    fine_d = fine_q;
    diff   = '0;
    sat    = '0;
    tmp    = '0;
    unique case (state_q)
      sthc_pkg::ST_T_MUL1: begin
        mul_a = {15'b0, adc_q[19:3]} - {15'b0, tc1_q, 1'b0};
        mul_b = t2;
      end
      sthc_pkg::ST_T_POST1: wa_d = 32'($signed(prod_q) >>> 11);
      sthc_pkg::ST_T_MUL2: begin
        mul_a = {16'b0, adc_q[19:4]} - t1;
        mul_b = {16'b0, adc_q[19:4]} - t1;
      end
      sthc_pkg::ST_T_POST2: wb_d = 32'($signed(prod_q) >>> 12);
      sthc_pkg::ST_T_MUL3: begin
        mul_a = wb_q;
        mul_b = t3;
      end
      sthc_pkg::ST_T_POST3: fine_d = wa_q + 32'($signed(prod_q) >>> 14);
      sthc_pkg::ST_T_MUL4: begin
        mul_a = fine_q;
        mul_b = sthc_pkg::TempScale;
      end
      sthc_pkg::ST_T_POST4: begin
        tmp = prod_q + sthc_pkg::TempRound;
        r_d = 32'($signed(tmp) >>> 8);
      end
      sthc_pkg::ST_H_MUL1: begin
        mul_a = h5;
        mul_b = x;
      end
      sthc_pkg::ST_H_POST1: begin
        tmp  = {2'b0, adc_q[15:0], 14'b0} - {h4, 20'b0} - prod_q + sthc_pkg::HumRoundA;
        pa_d = 32'($signed(tmp) >>> 15);
      end
      sthc_pkg::ST_H_MUL2: begin
        mul_a = x;
        mul_b = h6;
      end
      sthc_pkg::ST_H_POST2: wa_d = 32'($signed(prod_q) >>> 10);
      sthc_pkg::ST_H_MUL3: begin
        mul_a = x;
        mul_b = h3;
      end
      sthc_pkg::ST_H_POST3: wb_d = 32'($signed(prod_q) >>> 11) + sthc_pkg::HumBiasB;
      sthc_pkg::ST_H_MUL4: begin
        mul_a = wa_q;
        mul_b = wb_q;
      end
      sthc_pkg::ST_H_POST4: wb_d = 32'($signed(prod_q) >>> 10) + sthc_pkg::HumBiasC;
      sthc_pkg::ST_H_MUL5: begin
        mul_a = wb_q;
        mul_b = h2;
      end
      sthc_pkg::ST_H_POST5: begin
        tmp  = prod_q + sthc_pkg::HumRoundD;
        wb_d = 32'($signed(tmp) >>> 14);
      end
      sthc_pkg::ST_H_MUL6: begin
        mul_a = pa_q;
        mul_b = wb_q;
      end
      sthc_pkg::ST_H_POST6: begin
        r_d  = prod_q;
        wa_d = 32'($signed(prod_q) >>> 15);
      end
      sthc_pkg::ST_H_MUL7: begin
        mul_a = wa_q;
        mul_b = wa_q;
      end
      sthc_pkg::ST_H_POST7: wa_d = 32'($signed(prod_q) >>> 7);
      sthc_pkg::ST_H_MUL8: begin
        mul_a = wa_q;
        mul_b = h1;
      end
      sthc_pkg::ST_H_POST8: begin
        diff = r_q - 32'($signed(prod_q) >>> 4);
        // clamp to 0..100 percent
        if (diff[31]) begin
          sat = '0;
        end else if (diff > sthc_pkg::HumClampMax) begin
          sat = sthc_pkg::HumClampMax;
        end else begin
          sat = diff;
        end
        r_d = {15'b0, sat[28:12]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sthc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      fine_q      <= '0;
      tc1_q       <= '0;
      tc2_q       <= '0;
      tc3_q       <= '0;
      hc1_q       <= '0;
      hc2_q       <= '0;
      hc3_q       <= '0;
      hc45_q      <= '0;
      hc6_q       <= '0;
    end else begin
      state_q <= state_d;
      fine_q  <= fine_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          sthc_pkg::RegTempCoef1: tc1_q  <= cfg_data_i[15:0];
          sthc_pkg::RegTempCoef2: tc2_q  <= cfg_data_i[15:0];
          sthc_pkg::RegTempCoef3: tc3_q  <= cfg_data_i[15:0];
          sthc_pkg::RegHumCoef1:  hc1_q  <= cfg_data_i[7:0];
          sthc_pkg::RegHumCoef2:  hc2_q  <= cfg_data_i[15:0];
          sthc_pkg::RegHumCoef3:  hc3_q  <= cfg_data_i[7:0];
          sthc_pkg::RegHumCoef45: hc45_q <= cfg_data_i;
          sthc_pkg::RegHumCoef6:  hc6_q  <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= s_axis_tuser;
      adc_q <= s_axis_tdata[19:0];
    end
    prod_q <= prod_d;
    pa_q   <= pa_d;
    wa_q   <= wa_d;
    wb_q   <= wb_d;
    r_q    <= r_d;
    if (out_load) begin
      if (cmd_q == sthc_pkg::CmdHum) begin
        out_data_q <= {7'b0, r_q[16:0], 32'b0};
      end else begin
        out_data_q <= {7'b0, 17'b0, r_q};
      end
    end
  end

endmodule

### rtl/core/sthc_checker.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module sthc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [sthc_pkg::OutDataW-1:0] m_axis_tdata
);

  logic        in_req;
  logic        out_stall;
  logic [16:0] hum_q10;

  assign in_req    = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign hum_q10   = m_axis_tdata[48:32];

  `ASSERT_ALWAYS(a_rst_no_out, !rst_ni |-> !m_axis_tvalid, "output valid during reset")
  `ASSERT_CLKD(a_busy_after_req, in_req |=> !s_axis_tready, "ready right after request")
  `ASSERT_CLKD(a_out_busy, $rose(m_axis_tvalid) |-> $past(!s_axis_tready), "result unasked")
  `ASSERT_CLKD(a_out_hold, out_stall |=> m_axis_tvalid && $stable(m_axis_tdata), "result moved")
  `ASSERT_CLKD(a_hum_range, m_axis_tvalid |-> hum_q10 <= 17'd102400, "humidity above full scale")

endmodule

bind sensor_temp_humidity_compensation_unit sthc_checker u_sthc_checker (.*);

### test/sensor_temp_humidity_compensation_unit_test.sv
`timescale 1ns / 1ps

module sensor_temp_humidity_compensation_unit_test;

  localparam int ClkHalf      = 6;
  localparam int CycleLimit   = 500000;
  localparam int SettleCycles = 24;
  localparam int LongHold     = 400;
  localparam int PerPhase     = 100;
  localparam int RandPhases   = 8;
  localparam int ResetRows    = 6;
  localparam int DirectedRows = 18;

  localparam logic [sthc_pkg::CfgIdxW-1:0] RegPastEnd = 8'd9;
  localparam logic [sthc_pkg::CfgIdxW-1:0] RegLast    = 8'd255;

  localparam int FineOffset = 76800;
  localparam int RoundP     = 16384;
  localparam int BiasQ      = 32768;
  localparam int BiasQ2     = 2097152;
  localparam int RoundQ     = 8192;
  localparam int HumCeiling = 419430400;
  localparam int TempRnd    = 128;

  typedef struct {
    logic [15:0]        tc1;
    logic signed [15:0] tc2;
    logic signed [15:0] tc3;
    logic [7:0]         hc1;
    logic signed [15:0] hc2;
    logic [7:0]         hc3;
    logic [23:0]        hc45;
    logic signed [7:0]  hc6;
  } coef_set_t;

  typedef struct {
    logic signed [31:0] temp_centi;
    logic [16:0]        hum_q10;
  } reading_t;

  typedef struct {
    logic               cmd;
    logic [19:0]        raw;
    bit                 typed;
    logic signed [31:0] t;
    logic [16:0]        h;
  } sample_row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b1;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [sthc_pkg::InDataW-1:0]  s_axis_tdata = '0;
  logic                          s_axis_tuser = sthc_pkg::CmdTemp;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [sthc_pkg::OutDataW-1:0] m_axis_tdata;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [sthc_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [sthc_pkg::CfgDataW-1:0] cfg_data_i = '0;

  coef_set_t          cal;
  logic signed [31:0] fine_t;
  reading_t           readings_q[$];
  int                 mismatches = 0;
  int                 checked = 0;
  int                 temp_items = 0;
  int                 hum_items = 0;
  int                 coef_sets = 0;
  bit                 quiet = 1'b0;
  bit                 hold_req = 1'b0;

  sample_row_t directed [DirectedRows] = '{
    '{sthc_pkg::CmdHum,  20'h00000, 1'b1, 32'sd0, 17'd0},
    '{sthc_pkg::CmdHum,  20'hFFFFF, 1'b1, 32'sd0, 17'd0},
    '{sthc_pkg::CmdTemp, 20'h00000, 1'b1, 32'sd0, 17'd0},
    '{sthc_pkg::CmdTemp, 20'hFFFFF, 1'b1, 32'sd0, 17'd0},
    '{sthc_pkg::CmdHum,  20'h0FFFF, 1'b1, 32'sd0, 17'd0},
    '{sthc_pkg::CmdTemp, 20'h7EF20, 1'b1, 32'sd0, 17'd0},
    '{sthc_pkg::CmdHum,  20'h06C00, 1'b0, 32'sd0, 17'd0},
    '{sthc_pkg::CmdTemp, 20'd519888, 1'b0, 32'sd0, 17'd0},
    '{sthc_pkg::CmdHum,  20'd30000, 1'b0, 32'sd0, 17'd0},
    '{sthc_pkg::CmdHum,  20'hF7530, 1'b0, 32'sd0, 17'd0},
    '{sthc_pkg::CmdHum,  20'h00000, 1'b0, 32'sd0, 17'd0},
    '{sthc_pkg::CmdHum,  20'h0FFFF, 1'b0, 32'sd0, 17'd0},
    '{sthc_pkg::CmdTemp, 20'h00000, 1'b0, 32'sd0, 17'd0},
    '{sthc_pkg::CmdHum,  20'd30000, 1'b0, 32'sd0, 17'd0},
    '{sthc_pkg::CmdTemp, 20'hFFFFF, 1'b0, 32'sd0, 17'd0},
    '{sthc_pkg::CmdHum,  20'd30000, 1'b0, 32'sd0, 17'd0},
    '{sthc_pkg::CmdTemp, 20'h80000, 1'b0, 32'sd0, 17'd0},
    '{sthc_pkg::CmdHum,  20'hFFFFF, 1'b0, 32'sd0, 17'd0}
  };

  sensor_temp_humidity_compensation_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #ClkHalf clk_i = ~clk_i;

  function automatic coef_set_t typical_coefs();
    coef_set_t c;
    c.tc1  = 16'd27504;
    c.tc2  = 16'sd26435;
    c.tc3  = -16'sd1000;
    c.hc1  = 8'd75;
    c.hc2  = 16'sd362;
    c.hc3  = 8'd0;
    c.hc45 = {12'd50, 12'd313};
    c.hc6  = 8'sd30;
    return c;
  endfunction

  function automatic coef_set_t near_typical();
    coef_set_t c;
    c = typical_coefs();
    c.tc1  = c.tc1 + 16'($urandom_range(0, 4000) - 2000);
    c.tc2  = c.tc2 + 16'($urandom_range(0, 6000) - 3000);
    c.tc3  = c.tc3 + 16'($urandom_range(0, 1000) - 500);
    c.hc1  = 8'($urandom_range(40, 120));
    c.hc2  = 16'($urandom_range(250, 450));
    c.hc3  = 8'($urandom_range(0, 8));
    c.hc45 = {12'($urandom_range(0, 100)), 12'($urandom_range(250, 400))};
    c.hc6  = 8'($urandom_range(10, 40));
    return c;
  endfunction

  function automatic coef_set_t random_coefs();
    coef_set_t c;
    c.tc1  = 16'($urandom);
    c.tc2  = 16'($urandom);
    c.tc3  = 16'($urandom);
    c.hc1  = 8'($urandom);
    c.hc2  = 16'($urandom);
    c.hc3  = 8'($urandom);
    c.hc45 = 24'($urandom);
    c.hc6  = 8'($urandom);
    return c;
  endfunction

  function automatic int idle_len();
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void apply_reg(input logic [sthc_pkg::CfgIdxW-1:0] idx,
                                    input logic [sthc_pkg::CfgDataW-1:0] data);
    case (idx)
      sthc_pkg::RegTempCoef1: cal.tc1  = data[15:0];
      sthc_pkg::RegTempCoef2: cal.tc2  = data[15:0];
      sthc_pkg::RegTempCoef3: cal.tc3  = data[15:0];
      sthc_pkg::RegHumCoef1:  cal.hc1  = data[7:0];
      sthc_pkg::RegHumCoef2:  cal.hc2  = data[15:0];
      sthc_pkg::RegHumCoef3:  cal.hc3  = data[7:0];
      sthc_pkg::RegHumCoef45: cal.hc45 = data[23:0];
      sthc_pkg::RegHumCoef6:  cal.hc6  = data[7:0];
      default: ;
    endcase
  endfunction

  // signed 32-bit wrap everywhere, >>> is sign-filling
  function automatic reading_t compensate(input logic cmd, input logic [19:0] raw);
    reading_t res;
    int adc, t1, t2, t3, a, d, v1, v2;
    int h1, h2, h3, h4, h5, h6, x, p, q, r, sq;
    res.temp_centi = '0;
    res.hum_q10    = '0;
    if (cmd == sthc_pkg::CmdTemp) begin
      adc = int'(raw);
      t1  = int'(cal.tc1);
      t2  = int'(cal.tc2);
      t3  = int'(cal.tc3);
      a   = (adc >>> 3) - (t1 <<< 1);
      v1  = (a * t2) >>> 11;
      d   = (adc >>> 4) - t1;
      v2  = (((d * d) >>> 12) * t3) >>> 14;
      fine_t = v1 + v2;
      res.temp_centi = (fine_t * 5 + TempRnd) >>> 8;
    end else begin
      adc = int'(raw[15:0]);
      h1  = int'(cal.hc1);
      h2  = int'(cal.hc2);
      h3  = int'(cal.hc3);
      h4  = int'($signed(cal.hc45[11:0]));
      h5  = int'($signed(cal.hc45[23:12]));
      h6  = int'(cal.hc6);
      x   = fine_t - FineOffset;
      p   = ((adc <<< 14) - (h4 <<< 20) - (h5 * x) + RoundP) >>> 15;
      q   = ((((x * h6) >>> 10) * (((x * h3) >>> 11) + BiasQ)) >>> 10) + BiasQ2;
      q   = (q * h2 + RoundQ) >>> 14;
      r   = p * q;
      sq  = r >>> 15;
      r   = r - ((((sq * sq) >>> 7) * h1) >>> 4);
      if (r < 0) r = 0;
      if (r > HumCeiling) r = HumCeiling;
      res.hum_q10 = 17'(r >>> 12);
    end
    return res;
  endfunction

  task automatic write_reg(input logic [sthc_pkg::CfgIdxW-1:0] idx,
                           input logic [sthc_pkg::CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, data);
  endtask

  // unused upper data bits carry noise, the block must drop them
  task automatic program_coefs(input coef_set_t c);
    write_reg(sthc_pkg::RegTempCoef1, {8'($urandom), c.tc1});
    write_reg(sthc_pkg::RegTempCoef2, {8'($urandom), c.tc2});
    write_reg(sthc_pkg::RegTempCoef3, {8'($urandom), c.tc3});
    write_reg(sthc_pkg::RegHumCoef1,  {16'($urandom), c.hc1});
    write_reg(sthc_pkg::RegHumCoef2,  {8'($urandom), c.hc2});
    write_reg(sthc_pkg::RegHumCoef3,  {16'($urandom), c.hc3});
    write_reg(sthc_pkg::RegHumCoef45, c.hc45);
    write_reg(sthc_pkg::RegHumCoef6,  {16'($urandom), c.hc6});
    write_reg(RegPastEnd,   24'($urandom));
    cfg_valid_i <= 1'b0;
    coef_sets++;
  endtask

  task automatic send_sample(input logic cmd, input logic [19:0] raw, input bit typed,
                             input logic signed [31:0] t, input logic [16:0] h);
    int gap;
    reading_t want;
    gap = idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {{(sthc_pkg::InDataW-20){1'b0}}, raw};
    do @(posedge clk_i); while (!s_axis_tready);
    want = compensate(cmd, raw);
    if (typed) begin
      want.temp_centi = t;
      want.hum_q10    = h;
    end
    readings_q.push_back(want);
    if (cmd == sthc_pkg::CmdHum) hum_items++;
    else temp_items++;
  endtask

  task automatic finish_phase();
    s_axis_tvalid <= 1'b0;
    while (readings_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic check_reading(input logic [sthc_pkg::OutDataW-1:0] word);
    reading_t want;
    if (readings_q.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result, temperature %0d humidity %0d", $time,
               $signed(word[31:0]), word[48:32]);
      return;
    end
    want = readings_q.pop_front();
    checked++;
    if (word[31:0] !== want.temp_centi) begin
      mismatches++;
      $display("%0t: temperature_centi expected %0d got %0d", $time, want.temp_centi,
               $signed(word[31:0]));
    end
    if (word[48:32] !== want.hum_q10) begin
      mismatches++;
      $display("%0t: humidity_q10 expected %0d got %0d", $time, want.hum_q10, word[48:32]);
    end
  endtask

  task automatic send_random_phase();
    int n, k;
    logic [19:0] raw;
    n = 0;
    while (n < PerPhase) begin
      if ($urandom_range(0, 9) < 8) begin
        // calibration sequence: one temperature, then humidity readings that use it
        if ($urandom_range(0, 3) != 0) raw = 20'($urandom_range(380000, 620000));
        else raw = 20'($urandom);
        send_sample(sthc_pkg::CmdTemp, raw, 1'b0, '0, '0);
        n++;
        k = $urandom_range(1, 3);
        repeat (k) begin
          if ($urandom_range(0, 3) != 0) raw = {4'($urandom), 16'($urandom_range(15000, 50000))};
          else raw = 20'($urandom);
          send_sample(sthc_pkg::CmdHum, raw, 1'b0, '0, '0);
          n++;
        end
      end else begin
        send_sample($urandom_range(0, 1) ? sthc_pkg::CmdHum : sthc_pkg::CmdTemp,
                    20'($urandom), 1'b0, '0, '0);
        n++;
      end
    end
  endtask

  initial begin : timeout
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("%0t: timeout with %0d results outstanding", $time, readings_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : receiver
    int stall;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) check_reading(m_axis_tdata);
      if (hold_req) begin
        hold_req = 1'b0;
        stall = LongHold;
      end else if (stall == 0) begin
        stall = idle_len();
      end
      if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    coef_set_t c;
    rst_ni <= 1'b0;
    cal = '{default: '0};
    fine_t = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // out-of-range indexes must not touch any coefficient
    write_reg(RegPastEnd, 24'hFFFFFF);
    write_reg(RegLast, 24'hFFFFFF);
    cfg_valid_i <= 1'b0;

    for (int i = 0; i < DirectedRows; i++) begin
      if (i == ResetRows) begin
        finish_phase();
        program_coefs(typical_coefs());
      end
      send_sample(directed[i].cmd, directed[i].raw, directed[i].typed,
                  directed[i].t, directed[i].h);
    end
    finish_phase();

    for (int p = 0; p < RandPhases; p++) begin
      case (p)
        0: c = '{16'hFFFF, 16'sh7FFF, 16'sh7FFF, 8'hFF, 16'sh7FFF, 8'hFF, 24'h7FF7FF, 8'sh7F};
        1: c = '{16'h0000, 16'sh8000, 16'sh8000, 8'h00, 16'sh8000, 8'h00, 24'h800800, 8'sh80};
        2, 6: c = random_coefs();
        7: c = typical_coefs();
        default: c = near_typical();
      endcase
      program_coefs(c);
      quiet = (p == 2 || p == 5);
      if (p == 3) hold_req = 1'b1;
      send_random_phase();
      finish_phase();
    end

    $display("covered %0d temperature and %0d humidity samples under %0d coefficient sets",
             temp_items, hum_items, coef_sets);
    $display("%0d results compared, one %0d-cycle output stall, %0d mismatches",
             checked, LongHold, mismatches);
    if (mismatches == 0 && readings_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/sthc_pkg.sv
rtl/core/sensor_temp_humidity_compensation_unit.sv
rtl/core/sthc_checker.sv
test/sensor_temp_humidity_compensation_unit_test.sv
